/* rtl/eil4_pkg.sv */
// eil4_pkg: shared constants, status codes and the frame snapshot type
// for the ethernet / ipv4 / l4 header parser. No dependencies.
package eil4_pkg;

  // capture limit, byte counter saturates here
  localparam logic [15:0] MAX_CAPTURE_BYTES = 16'd65535;

  // header constants
  localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [5:0]  MIN_HDR_LEN    = 6'd20;
  localparam logic [7:0]  UDP_HDR_LEN    = 8'd8;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // fixed byte positions within the frame
  localparam logic [15:0] POS_SRC_MAC   = 16'd6;
  localparam logic [15:0] POS_ETYPE     = 16'd12;
  localparam logic [15:0] POS_IHL       = 16'd14;
  localparam logic [15:0] POS_PROTO     = 16'd23;
  localparam logic [15:0] POS_ADDR_LO   = 16'd26;
  localparam logic [15:0] POS_ADDR_HI   = 16'd34;

  // offsets within the l4 header
  localparam logic [15:0] REL_LEN_LO    = 16'd4;
  localparam logic [15:0] REL_LEN_HI    = 16'd6;
  localparam logic [15:0] REL_TCP_OFF   = 16'd12;
  localparam logic [15:0] REL_TCP_FLAGS = 16'd13;

  // result status codes
  localparam logic [2:0] ST_SHORT     = 3'd0;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd1;
  localparam logic [2:0] ST_BAD_IP    = 3'd2;
  localparam logic [2:0] ST_OTHER     = 3'd3;
  localparam logic [2:0] ST_BAD_TCP   = 3'd4;
  localparam logic [2:0] ST_TCP_OK    = 3'd5;
  localparam logic [2:0] ST_BAD_UDP   = 3'd6;
  localparam logic [2:0] ST_UDP_OK    = 3'd7;

  // per-frame latched state
  typedef struct packed {
    logic [15:0] byte_count;
    logic [47:0] mac_dest;
    logic [47:0] mac_src;
    logic [15:0] ether_type;
    logic [5:0]  ihl_bytes;
    logic [7:0]  proto;
    logic [63:0] ip_addrs;
    logic [63:0] l4_fields;
  } frame_state_t;

endpackage

/* rtl/eil4_ifs.sv */
// eil4_ifs: valid/ready channel interfaces for the frame byte input and
// the parse result output. No dependencies.
interface eil4_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eil4_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] dst_mac;
  logic [47:0] source_mac;
  logic [15:0] ether_type;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [7:0]  ip_proto;
  logic [5:0]  ip_hdr_bytes;
  logic [31:0] port_pair;
  logic [7:0]  tcp_flag_bits;
  logic [15:0] l4_length;
  logic [15:0] payload_bytes;

  modport source (output valid, output status, output dst_mac, output source_mac,
                  output ether_type, output src_addr, output dst_addr, output ip_proto,
                  output ip_hdr_bytes, output port_pair, output tcp_flag_bits,
                  output l4_length, output payload_bytes, input ready);
  modport sink   (input valid, input status, input dst_mac, input source_mac,
                  input ether_type, input src_addr, input dst_addr, input ip_proto,
                  input ip_hdr_bytes, input port_pair, input tcp_flag_bits,
                  input l4_length, input payload_bytes, output ready);
endinterface

/* rtl/ethernet_ipv4_l4_header_parser.sv */
// ethernet_ipv4_l4_header_parser: top level, field latch then classifier.
// Throughput: one frame byte per cycle, sustained under no backpressure.
// Two register stages lie between the edge that takes the marked last byte
// and a valid result (snapshot register, then result register).
// Reset (rst, synchronous, active high) clears the frame state and empties
// both stages. Depends on eil4_pkg, eil4_ifs, eil4_field_latch, eil4_classify.
module ethernet_ipv4_l4_header_parser (
  input  logic          clk,
  input  logic          rst,
  eil4_byte_if.sink     frame,
  eil4_result_if.source result
);

  eil4_pkg::frame_state_t snap;
  logic                   snap_valid;
  logic                   snap_ready;

  // byte counting and field capture
  eil4_field_latch u_latch (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready)
  );

  // status decision and result register
  eil4_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .result     (result)
  );

endmodule

/* rtl/eil4_field_latch.sv */
// eil4_field_latch: byte counter and header field latches; hands the
// finished frame state to the classifier. Depends on eil4_pkg, eil4_ifs.
module eil4_field_latch (
  input  logic                   clk,
  input  logic                   rst,
  eil4_byte_if.sink              frame,
  output eil4_pkg::frame_state_t snap,
  output logic                   snap_valid,
  input  logic                   snap_ready
);

  eil4_pkg::frame_state_t st;
  eil4_pkg::frame_state_t st_next;
  logic                   accept;
  logic [15:0]            pos;
  logic [7:0]             b;
  logic [6:0]             l4off;
  logic [15:0]            rel;

  assign frame.ready = !snap_valid || snap_ready;
  assign accept      = frame.valid && frame.ready;
  assign pos         = st.byte_count;
  assign b           = frame.data_byte;

  // field latch for the current byte position
  always_comb begin
    st_next = st;
    l4off   = 7'd0;
    rel     = 16'd0;
    if (pos < eil4_pkg::MAX_CAPTURE_BYTES) begin
      st_next.byte_count = pos + 16'd1;
      if (pos < eil4_pkg::POS_SRC_MAC) begin
        st_next.mac_dest = {st.mac_dest[39:0], b};
      end else if (pos < eil4_pkg::POS_ETYPE) begin
        st_next.mac_src = {st.mac_src[39:0], b};
      end else if (pos < eil4_pkg::POS_IHL) begin
        st_next.ether_type = {st.ether_type[7:0], b};
      end else if (pos == eil4_pkg::POS_IHL) begin
        st_next.ihl_bytes = {b[3:0], 2'b00};
      end else if (pos == eil4_pkg::POS_PROTO) begin
        st_next.proto = b;
      end else if (pos >= eil4_pkg::POS_ADDR_LO && pos < eil4_pkg::POS_ADDR_HI) begin
        st_next.ip_addrs = {st.ip_addrs[55:0], b};
      end
      // l4 header bytes, only with a sane ip header length
      l4off = eil4_pkg::ETH_HDR_LEN + {1'b0, st_next.ihl_bytes};
      rel   = pos - {9'd0, l4off};
      if (st_next.ihl_bytes >= eil4_pkg::MIN_HDR_LEN && pos >= {9'd0, l4off}) begin
        if (rel < eil4_pkg::REL_LEN_LO) begin
          st_next.l4_fields[63:32] = {st.l4_fields[55:32], b};
        end else if (rel < eil4_pkg::REL_LEN_HI) begin
          st_next.l4_fields[15:0] = {st.l4_fields[7:0], b};
        end else if (rel == eil4_pkg::REL_TCP_OFF) begin
          st_next.l4_fields[31:24] = b;
        end else if (rel == eil4_pkg::REL_TCP_FLAGS) begin
          st_next.l4_fields[23:16] = b;
        end
      end
    end
  end

  // frame state, cleared after the marked byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      if (frame.last_byte) begin
        st <= '0;
      end else begin
        st <= st_next;
      end
    end
  end

  // snapshot handoff to the classifier
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && frame.last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame.last_byte) begin
      snap <= st_next;
    end
  end

endmodule

/* rtl/eil4_classify.sv */
// eil4_classify: status decision, field gating and payload length into
// the result register. Depends on eil4_pkg, eil4_ifs.
module eil4_classify (
  input  logic                   clk,
  input  logic                   rst,
  input  eil4_pkg::frame_state_t snap,
  input  logic                   snap_valid,
  output logic                   snap_ready,
  eil4_result_if.source          result
);

  logic [15:0] cap;
  logic [6:0]  l4off;
  logic [5:0]  tcplen;
  logic [7:0]  tcp_end;
  logic [7:0]  udp_end;
  logic [7:0]  tcp_min_end;
  logic [2:0]  status;
  logic [31:0] ports;
  logic [7:0]  flags;
  logic [15:0] l4len;
  logic [15:0] payload;
  logic        load;

  assign snap_ready = !result.valid || result.ready;
  assign load       = snap_valid && snap_ready;

  assign cap         = snap.byte_count;
  assign l4off       = eil4_pkg::ETH_HDR_LEN + {1'b0, snap.ihl_bytes};
  assign tcplen      = {snap.l4_fields[31:28], 2'b00};
  assign tcp_end     = {1'b0, l4off} + {2'b00, tcplen};
  assign tcp_min_end = {1'b0, l4off} + {2'b00, eil4_pkg::MIN_HDR_LEN};
  assign udp_end     = {1'b0, l4off} + eil4_pkg::UDP_HDR_LEN;

  // parse status and l4 results
  always_comb begin
    ports   = 32'd0;
    flags   = 8'd0;
    l4len   = 16'd0;
    payload = 16'd0;
    if (cap < {9'd0, eil4_pkg::ETH_HDR_LEN}) begin
      status = eil4_pkg::ST_SHORT;
    end else if (snap.ether_type != eil4_pkg::ETHERTYPE_IPV4) begin
      status = eil4_pkg::ST_NOT_IPV4;
    end else if (cap < {8'd0, tcp_min_end} && snap.ihl_bytes == 6'd0) begin
      status = eil4_pkg::ST_BAD_IP;
    end else if (cap < 16'd34 || snap.ihl_bytes < eil4_pkg::MIN_HDR_LEN ||
                 cap < {9'd0, l4off}) begin
      status = eil4_pkg::ST_BAD_IP;
    end else if (snap.proto == eil4_pkg::PROTO_TCP) begin
      if (cap < {8'd0, tcp_min_end} || tcplen < eil4_pkg::MIN_HDR_LEN ||
          cap < {8'd0, tcp_end}) begin
        status = eil4_pkg::ST_BAD_TCP;
      end else begin
        status  = eil4_pkg::ST_TCP_OK;
        ports   = snap.l4_fields[63:32];
        flags   = snap.l4_fields[23:16];
        l4len   = {10'd0, tcplen};
        payload = cap - {8'd0, tcp_end};
      end
    end else if (snap.proto == eil4_pkg::PROTO_UDP) begin
      if (cap < {8'd0, udp_end}) begin
        status = eil4_pkg::ST_BAD_UDP;
      end else begin
        status  = eil4_pkg::ST_UDP_OK;
        ports   = snap.l4_fields[63:32];
        l4len   = snap.l4_fields[15:0];
        payload = cap - {8'd0, udp_end};
      end
    end else begin
      status = eil4_pkg::ST_OTHER;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // result payload, fields zeroed where parsing did not reach them
  always_ff @(posedge clk) begin
    if (load) begin
      result.status        <= status;
      result.dst_mac       <= (status != eil4_pkg::ST_SHORT) ? snap.mac_dest : 48'd0;
      result.source_mac    <= (status != eil4_pkg::ST_SHORT) ? snap.mac_src : 48'd0;
      result.ether_type    <= (status != eil4_pkg::ST_SHORT) ? snap.ether_type : 16'd0;
      result.src_addr      <= (status >= eil4_pkg::ST_OTHER) ? snap.ip_addrs[63:32] : 32'd0;
      result.dst_addr      <= (status >= eil4_pkg::ST_OTHER) ? snap.ip_addrs[31:0] : 32'd0;
      result.ip_proto      <= (status >= eil4_pkg::ST_OTHER) ? snap.proto : 8'd0;
      result.ip_hdr_bytes  <= (status >= eil4_pkg::ST_OTHER) ? snap.ihl_bytes : 6'd0;
      result.port_pair     <= ports;
      result.tcp_flag_bits <= flags;
      result.l4_length     <= l4len;
      result.payload_bytes <= payload;
    end
  end

endmodule

/* bench/testbench.sv */
// testbench: self-checking bench for ethernet_ipv4_l4_header_parser, directed frames
// then random frames under idling and output hold-off, checked by a header predictor.
// Depends on eil4_pkg, eil4_ifs and the parser rtl.
module testbench;

  localparam int RESET_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int PRESSURE_FRAMES = 16;
  localparam int PHASE_BYTES     = 40;
  localparam int PHASE_FRAMES    = 1;
  localparam int MAX_REPORTS     = 10;
  localparam int NUM_DIRECTED    = 21;
  localparam int PEND_DEPTH      = 16;

  // short names for the header values the frame table uses
  localparam logic [15:0] ET_IPV4 = eil4_pkg::ETHERTYPE_IPV4;
  localparam logic [7:0]  P_TCP   = eil4_pkg::PROTO_TCP;
  localparam logic [7:0]  P_UDP   = eil4_pkg::PROTO_UDP;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  // one frame to send: length, key header fields, filler and optional known status
  typedef struct packed {
    logic [16:0] length;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [3:0]  doff;
    fill_t       fill;
    logic        typed;
    logic [2:0]  status;
  } frame_spec_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] dst_mac;
    logic [47:0] source_mac;
    logic [15:0] ether_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  ip_proto;
    logic [5:0]  ip_hdr_bytes;
    logic [31:0] port_pair;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] l4_length;
    logic [15:0] payload_bytes;
  } parsed_header_t;

  // directed frames: length, ethertype, ihl, protocol, tcp data offset, filler, status
  localparam frame_spec_t DIRECTED_FRAMES [NUM_DIRECTED] = '{
    '{17'd1,   16'h0000, 4'd0,  8'd0,  4'd0,  FILL_RANDOM, 1'b1, eil4_pkg::ST_SHORT},
    '{17'd13,  16'h0000, 4'd0,  8'd0,  4'd0,  FILL_ZERO,   1'b1, eil4_pkg::ST_SHORT},
    '{17'd14,  16'hFFFF, 4'd15, 8'hFF, 4'd15, FILL_ONES,   1'b1, eil4_pkg::ST_NOT_IPV4},
    '{17'd20,  16'h86DD, 4'd5,  P_TCP, 4'd5,  FILL_RANDOM, 1'b1, eil4_pkg::ST_NOT_IPV4},
    '{17'd14,  ET_IPV4,  4'd5,  P_TCP, 4'd5,  FILL_RANDOM, 1'b1, eil4_pkg::ST_BAD_IP},
    '{17'd33,  ET_IPV4,  4'd5,  P_UDP, 4'd5,  FILL_RANDOM, 1'b1, eil4_pkg::ST_BAD_IP},
    '{17'd34,  ET_IPV4,  4'd4,  P_TCP, 4'd5,  FILL_RANDOM, 1'b1, eil4_pkg::ST_BAD_IP},
    '{17'd34,  ET_IPV4,  4'd0,  P_UDP, 4'd5,  FILL_ZERO,   1'b1, eil4_pkg::ST_BAD_IP},
    '{17'd73,  ET_IPV4,  4'd15, P_UDP, 4'd5,  FILL_RANDOM, 1'b1, eil4_pkg::ST_BAD_IP},
    '{17'd34,  ET_IPV4,  4'd5,  8'd1,  4'd5,  FILL_RANDOM, 1'b1, eil4_pkg::ST_OTHER},
    '{17'd74,  ET_IPV4,  4'd15, 8'hFF, 4'd15, FILL_ONES,   1'b1, eil4_pkg::ST_OTHER},
    '{17'd53,  ET_IPV4,  4'd5,  P_TCP, 4'd5,  FILL_RANDOM, 1'b1, eil4_pkg::ST_BAD_TCP},
    '{17'd54,  ET_IPV4,  4'd5,  P_TCP, 4'd4,  FILL_RANDOM, 1'b1, eil4_pkg::ST_BAD_TCP},
    '{17'd65,  ET_IPV4,  4'd5,  P_TCP, 4'd8,  FILL_RANDOM, 1'b1, eil4_pkg::ST_BAD_TCP},
    '{17'd54,  ET_IPV4,  4'd5,  P_TCP, 4'd5,  FILL_ZERO,   1'b1, eil4_pkg::ST_TCP_OK},
    '{17'd134, ET_IPV4,  4'd15, P_TCP, 4'd15, FILL_ONES,   1'b1, eil4_pkg::ST_TCP_OK},
    '{17'd41,  ET_IPV4,  4'd5,  P_UDP, 4'd5,  FILL_RANDOM, 1'b1, eil4_pkg::ST_BAD_UDP},
    '{17'd42,  ET_IPV4,  4'd5,  P_UDP, 4'd5,  FILL_ZERO,   1'b1, eil4_pkg::ST_UDP_OK},
    '{17'd82,  ET_IPV4,  4'd15, P_UDP, 4'd15, FILL_ONES,   1'b1, eil4_pkg::ST_UDP_OK},
    '{17'd64,  ET_IPV4,  4'd6,  P_TCP, 4'd6,  FILL_RANDOM, 1'b0, eil4_pkg::ST_SHORT},
    '{17'd60,  ET_IPV4,  4'd9,  P_UDP, 4'd5,  FILL_RANDOM, 1'b0, eil4_pkg::ST_SHORT}
  };

  localparam frame_spec_t ONE_BYTE_FRAME =
    '{17'd1, 16'h0000, 4'd0, 8'd0, 4'd0, FILL_RANDOM, 1'b1, eil4_pkg::ST_SHORT};

  logic clk;
  logic rst;

  eil4_byte_if   frame_if ();
  eil4_result_if result_if ();

  ethernet_ipv4_l4_header_parser uut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_if),
    .result (result_if)
  );

  // predictor state, mirrors the parser's per-frame latches
  int unsigned seen_bytes        = 0;
  logic [47:0] latched_dmac      = '0;
  logic [47:0] latched_smac      = '0;
  logic [15:0] latched_etype     = '0;
  int unsigned latched_ihl_bytes = 0;
  logic [7:0]  latched_proto     = '0;
  logic [63:0] latched_addrs     = '0;
  logic [63:0] latched_l4        = '0;

  // predicted headers waiting for their result, kept as a ring
  parsed_header_t pending [PEND_DEPTH];
  int unsigned    pend_wr = 0;
  int unsigned    pend_rd = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_output   = 1'b0;
  int unsigned bytes_sent    = 0;
  int unsigned frames_sent   = 0;
  int unsigned headers_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;
  int unsigned status_seen [8];

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // header predictor: latch one byte, on the marked byte classify and clear
  function automatic bit parse_byte(input logic [7:0] b, input logic is_last,
                                    output parsed_header_t hdr);
    int unsigned pos, cap, l4off, rel, tcp_len, hdr_end;
    logic [2:0]  st;
    hdr = '0;
    if (seen_bytes < eil4_pkg::MAX_CAPTURE_BYTES) begin
      pos = seen_bytes;
      if (pos < eil4_pkg::POS_SRC_MAC) latched_dmac = {latched_dmac[39:0], b};
      else if (pos < eil4_pkg::POS_ETYPE) latched_smac = {latched_smac[39:0], b};
      else if (pos < eil4_pkg::POS_IHL) latched_etype = {latched_etype[7:0], b};
      else if (pos == eil4_pkg::POS_IHL) latched_ihl_bytes = 4 * b[3:0];
      else if (pos == eil4_pkg::POS_PROTO) latched_proto = b;
      else if (pos >= eil4_pkg::POS_ADDR_LO && pos < eil4_pkg::POS_ADDR_HI) begin
        latched_addrs = {latched_addrs[55:0], b};
      end
      // l4 bytes only once a usable ip header length is known
      if (latched_ihl_bytes >= eil4_pkg::MIN_HDR_LEN) begin
        l4off = eil4_pkg::ETH_HDR_LEN + latched_ihl_bytes;
        if (pos >= l4off) begin
          rel = pos - l4off;
          if (rel < eil4_pkg::REL_LEN_LO) latched_l4[63:32] = {latched_l4[55:32], b};
          else if (rel < eil4_pkg::REL_LEN_HI) latched_l4[15:0] = {latched_l4[7:0], b};
          else if (rel == eil4_pkg::REL_TCP_OFF) latched_l4[31:24] = b;
          else if (rel == eil4_pkg::REL_TCP_FLAGS) latched_l4[23:16] = b;
        end
      end
      seen_bytes++;
    end
    if (!is_last) return 1'b0;

    cap   = seen_bytes;
    l4off = eil4_pkg::ETH_HDR_LEN + latched_ihl_bytes;
    if (cap < eil4_pkg::ETH_HDR_LEN) begin
      st = eil4_pkg::ST_SHORT;
    end else if (latched_etype != eil4_pkg::ETHERTYPE_IPV4) begin
      st = eil4_pkg::ST_NOT_IPV4;
    end else if (cap < eil4_pkg::ETH_HDR_LEN + eil4_pkg::MIN_HDR_LEN ||
                 latched_ihl_bytes < eil4_pkg::MIN_HDR_LEN || cap < l4off) begin
      st = eil4_pkg::ST_BAD_IP;
    end else if (latched_proto == eil4_pkg::PROTO_TCP) begin
      tcp_len = 4 * latched_l4[31:28];
      if (cap < l4off + eil4_pkg::MIN_HDR_LEN || tcp_len < eil4_pkg::MIN_HDR_LEN ||
          cap < l4off + tcp_len) begin
        st = eil4_pkg::ST_BAD_TCP;
      end else begin
        st                = eil4_pkg::ST_TCP_OK;
        hdr_end           = l4off + tcp_len;
        hdr.port_pair     = latched_l4[63:32];
        hdr.tcp_flag_bits = latched_l4[23:16];
        hdr.l4_length     = 16'(tcp_len);
        hdr.payload_bytes = (cap > hdr_end) ? 16'(cap - hdr_end) : 16'd0;
      end
    end else if (latched_proto == eil4_pkg::PROTO_UDP) begin
      if (cap < l4off + eil4_pkg::UDP_HDR_LEN) begin
        st = eil4_pkg::ST_BAD_UDP;
      end else begin
        st                = eil4_pkg::ST_UDP_OK;
        hdr_end           = l4off + eil4_pkg::UDP_HDR_LEN;
        hdr.port_pair     = latched_l4[63:32];
        hdr.l4_length     = latched_l4[15:0];
        hdr.payload_bytes = (cap > hdr_end) ? 16'(cap - hdr_end) : 16'd0;
      end
    end else begin
      st = eil4_pkg::ST_OTHER;
    end

    // fields the parse never reached stay zero
    hdr.status = st;
    if (st != eil4_pkg::ST_SHORT) begin
      hdr.dst_mac    = latched_dmac;
      hdr.source_mac = latched_smac;
      hdr.ether_type = latched_etype;
    end
    if (st >= eil4_pkg::ST_OTHER) begin
      hdr.src_addr     = latched_addrs[63:32];
      hdr.dst_addr     = latched_addrs[31:0];
      hdr.ip_proto     = latched_proto;
      hdr.ip_hdr_bytes = 6'(latched_ihl_bytes);
    end

    seen_bytes        = 0;
    latched_dmac      = '0;
    latched_smac      = '0;
    latched_etype     = '0;
    latched_ihl_bytes = 0;
    latched_proto     = '0;
    latched_addrs     = '0;
    latched_l4        = '0;
    return 1'b1;
  endfunction

  // byte at a given position of a frame, key header fields laid over the filler
  function automatic logic [7:0] frame_byte(input frame_spec_t spec, input int unsigned pos);
    int unsigned l4off;
    logic [7:0]  b;
    l4off = eil4_pkg::ETH_HDR_LEN + 4 * spec.ihl;
    case (spec.fill)
      FILL_ZERO: b = 8'h00;
      FILL_ONES: b = 8'hFF;
      default:   b = 8'($urandom_range(255));
    endcase
    if (pos == eil4_pkg::POS_ETYPE) b = spec.etype[15:8];
    else if (pos == eil4_pkg::POS_ETYPE + 1) b = spec.etype[7:0];
    else if (pos == eil4_pkg::POS_IHL) b = {b[7:4], spec.ihl};
    else if (pos == eil4_pkg::POS_PROTO) b = spec.proto;
    else if (spec.proto == P_TCP && pos == l4off + eil4_pkg::REL_TCP_OFF) begin
      b = {spec.doff, b[3:0]};
    end
    return b;
  endfunction

  // random frame: mostly well-formed tcp/udp, some short, foreign or cut off
  function automatic frame_spec_t random_frame_spec();
    frame_spec_t s;
    int unsigned pick, proto_pick, hdr_end;
    pick       = $urandom_range(99);
    proto_pick = $urandom_range(9);
    s.fill     = ($urandom_range(19) == 0) ? FILL_ZERO :
                 ($urandom_range(19) == 0) ? FILL_ONES : FILL_RANDOM;
    s.etype    = ET_IPV4;
    s.ihl      = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(15));
    s.proto    = (proto_pick < 4) ? P_TCP :
                 (proto_pick < 8) ? P_UDP : 8'($urandom_range(255));
    s.doff     = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(15));
    s.typed    = 1'b0;
    s.status   = eil4_pkg::ST_SHORT;
    hdr_end    = eil4_pkg::ETH_HDR_LEN + 4 * s.ihl +
                 ((s.proto == P_TCP) ? 4 * s.doff :
                  (s.proto == P_UDP) ? eil4_pkg::UDP_HDR_LEN : 0);
    if (pick < 8) begin
      s.length = 17'($urandom_range(13, 1));
    end else if (pick < 16) begin
      s.etype  = 16'($urandom_range(16'hFFFF));
      s.length = 17'($urandom_range(80, 14));
    end else if (pick < 30) begin
      s.length = 17'($urandom_range(hdr_end + 2, 14));
    end else begin
      s.length = 17'(hdr_end + $urandom_range(24));
    end
    return s;
  endfunction

  // one byte transaction on the frame channel, with random idle cycles first
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid     <= 1'b1;
    frame_if.data_byte <= b;
    frame_if.last_byte <= is_last;
    forever begin
      @(negedge clk);
      taken = frame_if.ready;
      @(posedge clk);
      if (taken) break;
    end
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_spec_t spec);
    parsed_header_t want;
    int unsigned    pos;
    logic [7:0]     b;
    logic           is_last;
    for (pos = 0; pos < spec.length; pos++) begin
      b       = frame_byte(spec, pos);
      is_last = (pos == spec.length - 1);
      send_byte(b, is_last);
      if (parse_byte(b, is_last, want)) begin
        if (spec.typed) want.status = spec.status;
        pending[pend_wr % PEND_DEPTH] = want;
        pend_wr++;
      end
    end
    frames_sent++;
  endtask

  task automatic run_random_phase();
    int unsigned start_bytes, start_frames;
    start_bytes  = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < PHASE_BYTES || frames_sent - start_frames < PHASE_FRAMES)
      send_frame(random_frame_spec());
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on header %0d, %s: expected %0h, got %0h",
                 headers_seen, name, want, got);
    end
  endtask

  // compare one result transaction with the oldest predicted header
  task automatic compare_header();
    parsed_header_t got, want;
    got = '{result_if.status, result_if.dst_mac, result_if.source_mac, result_if.ether_type,
            result_if.src_addr, result_if.dst_addr, result_if.ip_proto, result_if.ip_hdr_bytes,
            result_if.port_pair, result_if.tcp_flag_bits, result_if.l4_length,
            result_if.payload_bytes};
    if (pend_wr == pend_rd) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result with status %0d, no frame pending", got.status);
    end else begin
      want = pending[pend_rd % PEND_DEPTH];
      pend_rd++;
      status_seen[want.status]++;
      check_field("status", got.status, want.status);
      check_field("dst_mac", got.dst_mac, want.dst_mac);
      check_field("source_mac", got.source_mac, want.source_mac);
      check_field("ether_type", got.ether_type, want.ether_type);
      check_field("src_addr", got.src_addr, want.src_addr);
      check_field("dst_addr", got.dst_addr, want.dst_addr);
      check_field("ip_proto", got.ip_proto, want.ip_proto);
      check_field("ip_hdr_bytes", got.ip_hdr_bytes, want.ip_hdr_bytes);
      check_field("port_pair", got.port_pair, want.port_pair);
      check_field("tcp_flag_bits", got.tcp_flag_bits, want.tcp_flag_bits);
      check_field("l4_length", got.l4_length, want.l4_length);
      check_field("payload_bytes", got.payload_bytes, want.payload_bytes);
    end
    headers_seen++;
  endtask

  // result monitor, sampled mid-cycle so the transaction completes at the next edge
  always @(negedge clk) begin
    if (!rst && result_if.valid && result_if.ready) compare_header();
  end

  // watchdog on cycles with no transaction on either channel
  always @(negedge clk) begin
    if (rst || (frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles, %0d headers pending",
                 stall_cycles, pend_wr - pend_rd);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result ready: random idling, plus a long hold-off on request
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // stimulus and end of run
  initial begin
    rst                = 1'b1;
    frame_if.valid     = 1'b0;
    frame_if.data_byte = '0;
    frame_if.last_byte = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly idle
    send_idle_pct = 9;
    recv_idle_pct = 82;
    for (int i = 0; i < NUM_DIRECTED; i++) send_frame(DIRECTED_FRAMES[i]);
    run_random_phase();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 82;
    recv_idle_pct = 9;
    run_random_phase();

    // no idling; hold the output long enough to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_output   = 1'b1;
    repeat (PRESSURE_FRAMES) send_frame(ONE_BYTE_FRAME);
    run_random_phase();
    frame_if.valid <= 1'b0;

    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d frames in %0d bytes over three idling mixes and a %0d-cycle output stall",
             frames_sent, bytes_sent, HOLD_CYCLES);
    $display("headers by status: short %0d, non-ipv4 %0d, bad ip %0d, other %0d, bad tcp %0d,",
             status_seen[eil4_pkg::ST_SHORT], status_seen[eil4_pkg::ST_NOT_IPV4],
             status_seen[eil4_pkg::ST_BAD_IP], status_seen[eil4_pkg::ST_OTHER],
             status_seen[eil4_pkg::ST_BAD_TCP]);
    $display("  tcp %0d, bad udp %0d, udp %0d; %0d field mismatches",
             status_seen[eil4_pkg::ST_TCP_OK], status_seen[eil4_pkg::ST_BAD_UDP],
             status_seen[eil4_pkg::ST_UDP_OK], mismatches);
    if (mismatches == 0 && pend_wr == pend_rd) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
